/* rtl/core/scc_pkg.sv */
// scc_pkg: shared types, register encodings and reset constants for the
// system control coprocessor. No dependencies.

package scc_pkg;

  localparam int KEY_W = 11;

  // access encodings: {primary, secondary, opcode2}
  localparam logic [KEY_W-1:0] KEY_MAIN_ID    = {4'd0, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_CACHE_TYPE = {4'd0, 4'd0, 3'd1};
  localparam logic [KEY_W-1:0] KEY_TCM_SIZE   = {4'd0, 4'd0, 3'd2};
  localparam logic [KEY_W-1:0] KEY_CONTROL    = {4'd1, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_PROT_DC    = {4'd2, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_PROT_IC    = {4'd2, 4'd0, 3'd1};
  localparam logic [KEY_W-1:0] KEY_PROT_WB    = {4'd3, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_PROT_AD    = {4'd5, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_PROT_AI    = {4'd5, 4'd0, 3'd1};
  localparam logic [KEY_W-1:0] KEY_PROT_XAD   = {4'd5, 4'd0, 3'd2};
  localparam logic [KEY_W-1:0] KEY_PROT_XAI   = {4'd5, 4'd0, 3'd3};
  localparam logic [KEY_W-1:0] KEY_WFI_A      = {4'd7, 4'd0, 3'd4};
  localparam logic [KEY_W-1:0] KEY_WFI_B      = {4'd7, 4'd8, 3'd2};
  localparam logic [KEY_W-1:0] KEY_CM_50      = {4'd7, 4'd5, 3'd0};
  localparam logic [KEY_W-1:0] KEY_CM_51      = {4'd7, 4'd5, 3'd1};
  localparam logic [KEY_W-1:0] KEY_CM_52      = {4'd7, 4'd5, 3'd2};
  localparam logic [KEY_W-1:0] KEY_CM_60      = {4'd7, 4'd6, 3'd0};
  localparam logic [KEY_W-1:0] KEY_CM_61      = {4'd7, 4'd6, 3'd1};
  localparam logic [KEY_W-1:0] KEY_CM_62      = {4'd7, 4'd6, 3'd2};
  localparam logic [KEY_W-1:0] KEY_CM_A1      = {4'd7, 4'd10, 3'd1};
  localparam logic [KEY_W-1:0] KEY_CM_A2      = {4'd7, 4'd10, 3'd2};
  localparam logic [KEY_W-1:0] KEY_CM_A4      = {4'd7, 4'd10, 3'd4};
  localparam logic [KEY_W-1:0] KEY_CM_E1      = {4'd7, 4'd14, 3'd1};
  localparam logic [KEY_W-1:0] KEY_CM_E2      = {4'd7, 4'd14, 3'd2};
  localparam logic [KEY_W-1:0] KEY_LOCK_D     = {4'd9, 4'd0, 3'd0};
  localparam logic [KEY_W-1:0] KEY_LOCK_I     = {4'd9, 4'd0, 3'd1};
  localparam logic [KEY_W-1:0] KEY_DTCM       = {4'd9, 4'd1, 3'd0};
  localparam logic [KEY_W-1:0] KEY_ITCM       = {4'd9, 4'd1, 3'd1};

  localparam logic [3:0] PRIMARY_REGION = 4'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MAIN_ID    = 2'd0;
  localparam logic [1:0] CFG_CACHE_TYPE = 2'd1;
  localparam logic [1:0] CFG_TCM_SIZE   = 2'd2;

  localparam logic [31:0] MAIN_ID_RESET    = 32'h4105_9461;
  localparam logic [31:0] CACHE_TYPE_RESET = 32'h0F0D_2112;
  localparam logic [31:0] TCM_SIZE_RESET   = 32'h0014_0180;
  localparam logic [31:0] CONTROL_RESET    = 32'h0000_2078;
  localparam logic [31:0] CONTROL_WMASK    = 32'h000F_F085;
  localparam logic [31:0] DTCM_BASE_MASK   = 32'hFFFF_F000;
  localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

  localparam int CTRL_ITCM_EN = 18;
  localparam int CTRL_DTCM_EN = 16;

  localparam int PROT_COUNT = 7;

  typedef struct packed {
    logic        action;
    logic [3:0]  primary_reg;
    logic [3:0]  secondary_reg;
    logic [2:0]  opcode_two;
    logic [31:0] write_data;
  } req_t;

  // state after the access, as needed for the tcm outputs
  typedef struct packed {
    logic [31:0] control_word;
    logic [31:0] itcm_setting;
    logic [31:0] dtcm_setting;
  } tcm_state_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_known;
    logic        halt_request;
  } bank_rsp_t;

  typedef struct packed {
    logic [31:0] itcm_start;
    logic [31:0] itcm_addr_mask;
    logic [31:0] dtcm_start;
    logic [31:0] dtcm_addr_mask;
  } tcm_map_t;

endpackage

/* rtl/core/system_control_coprocessor.sv */
// system_control_coprocessor: top level with request and result registers.
// Depends on scc_pkg, scc_bank and scc_tcm.
//
// Usage: each request on the in_ channel is one register access (read or
// write, picked by in_tuser) addressed by primary register, secondary
// register and opcode2. Every request gives exactly one result on the out_
// channel: read data, a known-encoding flag, a halt request flag for
// wait-for-interrupt writes, and the current instruction and data TCM base
// and mask (after the access takes effect).
// A request taken into the request register is decoded from it by the
// bank, and its result is captured in the result register and presented
// from out_tdata once that register is free or out_tready is high.
// Throughput: one request per cycle while out_tready is high.
// A stalled out_tready holds the result; the request register still holds
// one more request, after which in_tready drops.
// The cfg_ port writes the read-only identification values; write it only
// while no request is in flight.
// Reset (rst_n low at a clock edge) empties both registers and returns all
// coprocessor state and identification values to their reset values.

module system_control_coprocessor #(
  parameter int REGION_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // primary_reg, secondary_reg, opcode_two, write_data
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // read_data, access_known, halt_request,
                                   // itcm_start, itcm_addr_mask, dtcm_start,
                                   // dtcm_addr_mask
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  scc_pkg::req_t       req_r;
  logic                req_valid_r;
  scc_pkg::bank_rsp_t  rsp;
  scc_pkg::tcm_state_t tcm_state;
  scc_pkg::tcm_map_t   map;
  logic [167:0]        out_data_r, out_data_nxt;
  logic                out_valid_r;
  logic                advance;

  assign advance   = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.action        <= in_tuser;
      req_r.primary_reg   <= in_tdata[3:0];
      req_r.secondary_reg <= in_tdata[7:4];
      req_r.opcode_two    <= in_tdata[10:8];
      req_r.write_data    <= in_tdata[42:11];
    end
  end

  scc_bank #(
    .REGION_COUNT(REGION_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .en        (advance),
    .req       (req_r),
    .rsp       (rsp),
    .tcm_state (tcm_state)
  );

  scc_tcm u_tcm (
    .st  (tcm_state),
    .map (map)
  );

  assign out_data_nxt = {6'd0, map.dtcm_addr_mask, map.dtcm_start, map.itcm_addr_mask,
                         map.itcm_start, rsp.halt_request, rsp.access_known,
                         rsp.read_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/core/scc_bank.sv */
// scc_bank: register bank with access decode, read mux and write update.
// Depends on scc_pkg.

module scc_bank #(
  parameter int REGION_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                en,
  input  scc_pkg::req_t       req,
  output scc_pkg::bank_rsp_t  rsp,
  output scc_pkg::tcm_state_t tcm_state
);

  localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  logic [31:0] main_id_r, cache_type_r, tcm_size_r;
  logic [31:0] control_r, control_nxt;
  logic [31:0] dtcm_r, dtcm_nxt;
  logic [31:0] itcm_r, itcm_nxt;
  logic [31:0] lock_d_r, lock_i_r;
  logic [31:0] prot_r [scc_pkg::PROT_COUNT];
  logic [31:0] dregion_r [REGION_COUNT];
  logic [31:0] iregion_r [REGION_COUNT];

  logic [scc_pkg::KEY_W-1:0] key;
  logic                      prot_hit;
  logic [2:0]                prot_slot;
  logic                      region_hit;
  logic [IDX_W-1:0]          ridx;
  logic                      cache_op;
  logic                      wr_prot, wr_dregion, wr_iregion, wr_lock_d, wr_lock_i;

  assign key  = {req.primary_reg, req.secondary_reg, req.opcode_two};
  assign ridx = req.secondary_reg[IDX_W-1:0];
  assign region_hit = (req.primary_reg == scc_pkg::PRIMARY_REGION) &&
                      (req.opcode_two <= 3'd1) &&
                      (32'(req.secondary_reg) < 32'(REGION_COUNT));

  always_comb begin
    prot_hit  = 1'b1;
    prot_slot = 3'd0;
    case (key)
      scc_pkg::KEY_PROT_DC:  prot_slot = 3'd0;
      scc_pkg::KEY_PROT_IC:  prot_slot = 3'd1;
      scc_pkg::KEY_PROT_WB:  prot_slot = 3'd2;
      scc_pkg::KEY_PROT_AD:  prot_slot = 3'd3;
      scc_pkg::KEY_PROT_AI:  prot_slot = 3'd4;
      scc_pkg::KEY_PROT_XAD: prot_slot = 3'd5;
      scc_pkg::KEY_PROT_XAI: prot_slot = 3'd6;
      default:               prot_hit  = 1'b0;
    endcase
  end

  always_comb begin
    case (key)
      scc_pkg::KEY_CM_50, scc_pkg::KEY_CM_51, scc_pkg::KEY_CM_52,
      scc_pkg::KEY_CM_60, scc_pkg::KEY_CM_61, scc_pkg::KEY_CM_62,
      scc_pkg::KEY_CM_A1, scc_pkg::KEY_CM_A2, scc_pkg::KEY_CM_A4,
      scc_pkg::KEY_CM_E1, scc_pkg::KEY_CM_E2: cache_op = 1'b1;
      default:                                 cache_op = 1'b0;
    endcase
  end

  always_comb begin
    rsp.read_data    = '0;
    rsp.access_known = 1'b1;
    rsp.halt_request = 1'b0;
    control_nxt = control_r;
    dtcm_nxt    = dtcm_r;
    itcm_nxt    = itcm_r;
    wr_prot     = 1'b0;
    wr_dregion  = 1'b0;
    wr_iregion  = 1'b0;
    wr_lock_d   = 1'b0;
    wr_lock_i   = 1'b0;
    if (!req.action) begin
      if (key == scc_pkg::KEY_MAIN_ID)         rsp.read_data = main_id_r;
      else if (key == scc_pkg::KEY_CACHE_TYPE) rsp.read_data = cache_type_r;
      else if (key == scc_pkg::KEY_TCM_SIZE)   rsp.read_data = tcm_size_r;
      else if (key == scc_pkg::KEY_CONTROL)    rsp.read_data = control_r;
      else if (prot_hit)                       rsp.read_data = prot_r[prot_slot];
      else if (region_hit)
        rsp.read_data = req.opcode_two[0] ? iregion_r[ridx] : dregion_r[ridx];
      else if (key == scc_pkg::KEY_LOCK_D)     rsp.read_data = lock_d_r;
      else if (key == scc_pkg::KEY_LOCK_I)     rsp.read_data = lock_i_r;
      else if (key == scc_pkg::KEY_DTCM)       rsp.read_data = dtcm_r;
      else if (key == scc_pkg::KEY_ITCM)       rsp.read_data = itcm_r;
      else                                     rsp.access_known = 1'b0;
    end else begin
      if (key == scc_pkg::KEY_CONTROL)
        control_nxt = (control_r & ~scc_pkg::CONTROL_WMASK) |
                      (req.write_data & scc_pkg::CONTROL_WMASK);
      else if (prot_hit)                       wr_prot = 1'b1;
      else if (region_hit) begin
        wr_iregion = req.opcode_two[0];
        wr_dregion = ~req.opcode_two[0];
      end
      else if (key == scc_pkg::KEY_WFI_A || key == scc_pkg::KEY_WFI_B)
        rsp.halt_request = 1'b1;
      else if (cache_op) begin
        // maintenance operations have no effect here
      end
      else if (key == scc_pkg::KEY_LOCK_D)     wr_lock_d = 1'b1;
      else if (key == scc_pkg::KEY_LOCK_I)     wr_lock_i = 1'b1;
      else if (key == scc_pkg::KEY_DTCM)       dtcm_nxt = req.write_data;
      else if (key == scc_pkg::KEY_ITCM)       itcm_nxt = req.write_data;
      else                                     rsp.access_known = 1'b0;
    end
  end

  assign tcm_state.control_word = control_nxt;
  assign tcm_state.itcm_setting = itcm_nxt;
  assign tcm_state.dtcm_setting = dtcm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_id_r    <= scc_pkg::MAIN_ID_RESET;
      cache_type_r <= scc_pkg::CACHE_TYPE_RESET;
      tcm_size_r   <= scc_pkg::TCM_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_MAIN_ID:    main_id_r    <= cfg_wdata;
        scc_pkg::CFG_CACHE_TYPE: cache_type_r <= cfg_wdata;
        scc_pkg::CFG_TCM_SIZE:   tcm_size_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= scc_pkg::CONTROL_RESET;
      dtcm_r    <= '0;
      itcm_r    <= '0;
      lock_d_r  <= '0;
      lock_i_r  <= '0;
      for (int i = 0; i < scc_pkg::PROT_COUNT; i++) prot_r[i] <= '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        dregion_r[i] <= '0;
        iregion_r[i] <= '0;
      end
    end else if (en) begin
      control_r <= control_nxt;
      dtcm_r    <= dtcm_nxt;
      itcm_r    <= itcm_nxt;
      if (wr_lock_d)  lock_d_r            <= req.write_data;
      if (wr_lock_i)  lock_i_r            <= req.write_data;
      if (wr_prot)    prot_r[prot_slot]   <= req.write_data;
      if (wr_dregion) dregion_r[ridx]     <= req.write_data;
      if (wr_iregion) iregion_r[ridx]     <= req.write_data;
    end
  end

endmodule

/* rtl/core/scc_tcm.sv */
// scc_tcm: tightly coupled memory base and mask from control and settings.
// Depends on scc_pkg.

module scc_tcm (
  input  scc_pkg::tcm_state_t st,
  output scc_pkg::tcm_map_t   map
);

  logic [31:0] itcm_size_mask, dtcm_size_mask;

  // size field clamped to 3..23, mask = (0x200 << size) - 1 mod 2^32
  function automatic logic [31:0] mask_of(input logic [31:0] setting);
    logic [4:0]  size;
    logic [32:0] span;
    size = setting[5:1];
    if (size < 5'd3)  size = 5'd3;
    if (size > 5'd23) size = 5'd23;
    span = 33'h200 << size;
    return 32'(span - 33'd1);
  endfunction

  assign itcm_size_mask = mask_of(st.itcm_setting);
  assign dtcm_size_mask = mask_of(st.dtcm_setting);

  always_comb begin
    if (st.control_word[scc_pkg::CTRL_ITCM_EN]) begin
      map.itcm_start     = '0;
      map.itcm_addr_mask = itcm_size_mask;
    end else begin
      map.itcm_start     = scc_pkg::ALL_ONES;
      map.itcm_addr_mask = '0;
    end
    if (st.control_word[scc_pkg::CTRL_DTCM_EN]) begin
      map.dtcm_start     = st.dtcm_setting & scc_pkg::DTCM_BASE_MASK;
      map.dtcm_addr_mask = dtcm_size_mask;
    end else begin
      map.dtcm_start     = scc_pkg::ALL_ONES;
      map.dtcm_addr_mask = '0;
    end
  end

endmodule
